### rtl/amcstx_pkg.sv
// shared types and constants for the audio module command serial transmitter
`default_nettype none

package amcstx_pkg;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_PLAY   = 2'd1,
    CMD_VOLUME = 2'd2,
    CMD_STOP   = 2'd3
  } cmd_e;

  localparam logic [15:0] BIT_TIME_RESET = 16'd93;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] arg;
  } item_t;

  // packed so that line sits in bit 0
  typedef struct packed {
    logic accepted;
    logic busy;
    logic line;
  } res_t;

endpackage

`default_nettype wire

### rtl/audio_module_command_serial_tx.sv
// Serial command transmitter for an audio player module.
// The slave stream carries one item per cycle while tready is high: tuser holds
// the command (tick, play, volume, stop) and tdata the track or volume byte. Each
// command starts a frame when the transmitter is idle, else it is dropped.
// Tick items advance the bit timer; a serial bit lasts bit_time ticks, or one
// if it is zero. Every item yields exactly one result item on the master
// stream: the line level after the item, the busy flag and the accepted flag.
// An accepted item waits in the input register until the state update loads
// its result into the result register. Throughput is one item per cycle while
// the receiver does not stall, set by the single state update step.
// bit_time is written through cfg_we_i/cfg_wdata_i; the user must do so only
// while the block is idle, as the block itself does not enforce it. Reset drives
// the line state high, clears the frame state and loads bit_time with 93. When
// the receiver stalls the result register holds its item and the input register
// fills; tready drops only when both stages are full.
`default_nettype none

module audio_module_command_serial_tx (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [15:0] cfg_wdata_i,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] arg
  input  wire  [1:0]  s_axis_tuser,   // [1:0] cmd
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [0] line, [1] busy_res, [2] accepted, [7:3] zero
);

  logic [15:0]        bit_time_q;
  amcstx_pkg::item_t  in_item;
  amcstx_pkg::item_t  stage_item;
  amcstx_pkg::res_t   core_res;
  amcstx_pkg::res_t   out_res;
  logic               stage_valid;
  logic               adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_time_q <= amcstx_pkg::BIT_TIME_RESET;
    end else if (cfg_we_i) begin
      bit_time_q <= cfg_wdata_i;
    end
  end

  assign in_item.cmd = amcstx_pkg::cmd_e'(s_axis_tuser);
  assign in_item.arg = s_axis_tdata;

  assign adv = stage_valid && (!m_axis_tvalid || m_axis_tready);

  amcstx_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .adv_i      (adv),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  amcstx_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (adv),
    .item_i     (stage_item),
    .bit_time_i (bit_time_q),
    .res_o      (core_res)
  );

  amcstx_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (adv),
    .res_i   (core_res),
    .ready_i (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .res_o   (out_res)
  );

  assign m_axis_tdata = {5'd0, out_res};

`ifndef SYNTHESIS
  // a started frame is always reported busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1])
    else $error("accepted item not busy");

  // idle line is high
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[1] |-> m_axis_tdata[0])
    else $error("line low while idle");

  // input stalls only behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output back-pressure");
`endif

endmodule

`default_nettype wire

### rtl/amcstx_in_reg.sv
// input register stage holding one accepted command or tick item
`default_nettype none

module amcstx_in_reg (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  amcstx_pkg::item_t   in_item_i,
  input  wire                 adv_i,
  output logic                valid_o,
  output amcstx_pkg::item_t   item_o
);

  logic              valid_q;
  amcstx_pkg::item_t item_q;

  assign in_ready_o = !valid_q || adv_i;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

endmodule

`default_nettype wire

### rtl/amcstx_core.sv
// frame state, bit timer and line level update for one item
`default_nettype none

module amcstx_core (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 step_i,
  input  amcstx_pkg::item_t   item_i,
  input  wire [15:0]          bit_time_i,
  output amcstx_pkg::res_t    res_o
);

  localparam logic [3:0] PhasesPerByte = 4'd11;
  localparam logic [3:0] PhaseStart    = 4'd2;
  localparam logic [3:0] PhaseData0    = 4'd3;
  localparam logic [7:0] ByteSync      = 8'hFD;
  localparam logic [7:0] ByteEnd       = 8'hDF;
  localparam logic [7:0] PlayLen       = 8'h04;
  localparam logic [7:0] PlayOp        = 8'h41;
  localparam logic [7:0] PlayHigh      = 8'h00;
  localparam logic [7:0] VolLen        = 8'h03;
  localparam logic [7:0] VolOp         = 8'h31;
  localparam logic [7:0] StopLen       = 8'h02;
  localparam logic [7:0] StopOp        = 8'h02;

  function automatic logic [2:0] frame_len(amcstx_pkg::cmd_e kind);
    unique case (kind)
      amcstx_pkg::CMD_PLAY:   frame_len = 3'd6;
      amcstx_pkg::CMD_VOLUME: frame_len = 3'd5;
      default:                frame_len = 3'd4;
    endcase
  endfunction

  function automatic logic [7:0] frame_byte(amcstx_pkg::cmd_e kind, logic [2:0] pos,
                                            logic [7:0] arg);
    logic [7:0] b;
    b = 8'hFF;
    unique case (kind)
      amcstx_pkg::CMD_PLAY: begin
        case (pos)
          3'd0:    b = ByteSync;
          3'd1:    b = PlayLen;
          3'd2:    b = PlayOp;
          3'd3:    b = PlayHigh;
          3'd4:    b = arg;
          3'd5:    b = ByteEnd;
          default: b = 8'hFF;
        endcase
      end
      amcstx_pkg::CMD_VOLUME: begin
        case (pos)
          3'd0:    b = ByteSync;
          3'd1:    b = VolLen;
          3'd2:    b = VolOp;
          3'd3:    b = arg;
          3'd4:    b = ByteEnd;
          default: b = 8'hFF;
        endcase
      end
      default: begin
        case (pos)
          3'd0:    b = ByteSync;
          3'd1:    b = StopLen;
          3'd2:    b = StopOp;
          3'd3:    b = ByteEnd;
          default: b = 8'hFF;
        endcase
      end
    endcase
    return b;
  endfunction

  logic              line_q, line_d;
  logic              sending_q, sending_d;
  amcstx_pkg::cmd_e  kind_q, kind_d;
  logic [7:0]        arg_q, arg_d;
  logic [2:0]        pos_q, pos_d;
  logic [3:0]        phase_q, phase_d;
  logic [15:0]       tick_q, tick_d;

  logic              acc;
  logic [15:0]       limit;
  logic [16:0]       cnt;
  logic [3:0]        ph_inc;
  logic [2:0]        pos_inc;
  logic [3:0]        bit_sel;
  logic [7:0]        cur_byte;

  always_comb begin
    line_d    = line_q;
    sending_d = sending_q;
    kind_d    = kind_q;
    arg_d     = arg_q;
    pos_d     = pos_q;
    phase_d   = phase_q;
    tick_d    = tick_q;
    acc       = 1'b0;
    limit     = (bit_time_i == 16'd0) ? 16'd1 : bit_time_i;
    cnt       = {1'b0, tick_q} + 17'd1;
    ph_inc    = phase_q + 4'd1;
    pos_inc   = pos_q + 3'd1;
    if (item_i.cmd != amcstx_pkg::CMD_TICK) begin
      if (!sending_q) begin
        sending_d = 1'b1;
        kind_d    = item_i.cmd;
        arg_d     = item_i.arg;
        pos_d     = 3'd0;
        phase_d   = 4'd0;
        tick_d    = 16'd0;
        line_d    = 1'b1;
        acc       = 1'b1;
      end
    end else if (sending_q) begin
      if (cnt >= {1'b0, limit}) begin
        tick_d  = 16'd0;
        phase_d = ph_inc;
        if (ph_inc >= PhasesPerByte) begin
          phase_d = 4'd0;
          pos_d   = pos_inc;
          if (pos_inc >= frame_len(kind_q)) begin
            sending_d = 1'b0;
            pos_d     = 3'd0;
          end
        end
      end else begin
        tick_d = cnt[15:0];
      end
    end
  end

  // level of the new phase, idle and start bits ahead of the data bits
  assign bit_sel  = phase_d - PhaseData0;
  assign cur_byte = frame_byte(kind_q, pos_d, arg_q);

  logic line_next;
  always_comb begin
    if (!sending_d) begin
      line_next = 1'b1;
    end else if (phase_d < PhaseStart) begin
      line_next = 1'b1;
    end else if (phase_d == PhaseStart) begin
      line_next = 1'b0;
    end else begin
      line_next = cur_byte[bit_sel[2:0]];
    end
  end

  logic line_upd;
  assign line_upd = (item_i.cmd != amcstx_pkg::CMD_TICK) ? line_d
                  : (sending_q && cnt >= {1'b0, limit}) ? line_next : line_q;

  assign res_o.line     = line_upd;
  assign res_o.busy     = sending_d;
  assign res_o.accepted = acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q    <= 1'b1;
      sending_q <= 1'b0;
      kind_q    <= amcstx_pkg::CMD_TICK;
      arg_q     <= 8'd0;
      pos_q     <= 3'd0;
      phase_q   <= 4'd0;
      tick_q    <= 16'd0;
    end else if (step_i) begin
      line_q    <= line_upd;
      sending_q <= sending_d;
      kind_q    <= kind_d;
      arg_q     <= arg_d;
      pos_q     <= pos_d;
      phase_q   <= phase_d;
      tick_q    <= tick_d;
    end
  end

endmodule

`default_nettype wire

### rtl/amcstx_out_reg.sv
// result register holding one item until the receiver takes it
`default_nettype none

module amcstx_out_reg (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 load_i,
  input  amcstx_pkg::res_t    res_i,
  input  wire                 ready_i,
  output logic                valid_o,
  output amcstx_pkg::res_t    res_o
);

  logic             valid_q;
  amcstx_pkg::res_t res_q;

  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

### dv/tb.sv
// testbench for the audio module command serial transmitter: directed and random stream checks
`default_nettype none

module tb;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] arg
  logic [1:0]  s_axis_tuser = '0;   // [1:0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [0] line, [1] busy_res, [2] accepted, [7:3] zero

  audio_module_command_serial_tx dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  // transmitter state as predicted
  logic [15:0]       tx_bit_time;
  logic              tx_line;
  logic              tx_sending;
  amcstx_pkg::cmd_e  tx_kind;
  logic [7:0]        tx_arg;
  logic [2:0]        tx_byte_pos;
  logic [3:0]        tx_phase;
  logic [15:0]       tx_ticks;

  amcstx_pkg::res_t pending_line_states[$];
  int   failures = 0;
  bit   idle_on = 1'b1;
  int   hold_left = 0;

  task automatic advance_transmitter(input amcstx_pkg::cmd_e cmd, input logic [7:0] arg,
                                     output amcstx_pkg::res_t r);
    logic [16:0] limit;
    logic [16:0] cnt;
    logic [7:0]  octet;
    logic [2:0]  frame_len;
    logic [3:0]  bitno;
    r.accepted = 1'b0;
    if (cmd != amcstx_pkg::CMD_TICK) begin
      if (!tx_sending) begin
        tx_sending  = 1'b1;
        tx_kind     = cmd;
        tx_arg      = arg;
        tx_byte_pos = '0;
        tx_phase    = '0;
        tx_ticks    = '0;
        tx_line     = 1'b1;
        r.accepted  = 1'b1;
      end
    end else if (tx_sending) begin
      limit = (tx_bit_time == 16'd0) ? 17'd1 : {1'b0, tx_bit_time};
      cnt   = {1'b0, tx_ticks} + 17'd1;
      if (cnt >= limit) begin
        tx_ticks = '0;
        tx_phase = tx_phase + 4'd1;
        if (tx_phase >= 4'd11) begin
          tx_phase    = '0;
          tx_byte_pos = tx_byte_pos + 3'd1;
          frame_len   = (tx_kind == amcstx_pkg::CMD_PLAY) ? 3'd6
                      : (tx_kind == amcstx_pkg::CMD_VOLUME) ? 3'd5 : 3'd4;
          if (tx_byte_pos >= frame_len) begin
            tx_sending  = 1'b0;
            tx_byte_pos = '0;
          end
        end
        case (tx_kind)
          amcstx_pkg::CMD_PLAY: begin
            case (tx_byte_pos)
              3'd0: octet = 8'hFD;
              3'd1: octet = 8'h04;
              3'd2: octet = 8'h41;
              3'd3: octet = 8'h00;
              3'd4: octet = tx_arg;
              3'd5: octet = 8'hDF;
              default: octet = 8'hFF;
            endcase
          end
          amcstx_pkg::CMD_VOLUME: begin
            case (tx_byte_pos)
              3'd0: octet = 8'hFD;
              3'd1: octet = 8'h03;
              3'd2: octet = 8'h31;
              3'd3: octet = tx_arg;
              3'd4: octet = 8'hDF;
              default: octet = 8'hFF;
            endcase
          end
          default: begin
            case (tx_byte_pos)
              3'd0: octet = 8'hFD;
              3'd1: octet = 8'h02;
              3'd2: octet = 8'h02;
              3'd3: octet = 8'hDF;
              default: octet = 8'hFF;
            endcase
          end
        endcase
        bitno = tx_phase - 4'd3;
        if (!tx_sending || tx_phase < 4'd2) tx_line = 1'b1;
        else if (tx_phase == 4'd2) tx_line = 1'b0;
        else tx_line = octet[bitno[2:0]];
      end else begin
        tx_ticks = cnt[15:0];
      end
    end
    r.line = tx_line;
    r.busy = tx_sending;
  endtask

  // compare results first, then predict the item taken at this edge
  always @(posedge clk_i) begin : score
    amcstx_pkg::res_t got;
    amcstx_pkg::res_t want;
    amcstx_pkg::res_t nxt;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = amcstx_pkg::res_t'(m_axis_tdata[2:0]);
        if (pending_line_states.size() == 0) begin
          $error("result with no item pending: tdata %h", m_axis_tdata);
          failures++;
        end else begin
          want = pending_line_states.pop_front();
          if (got.line != want.line) begin
            $error("line: expected %0d, actual %0d", want.line, got.line);
            failures++;
          end
          if (got.busy != want.busy) begin
            $error("busy_res: expected %0d, actual %0d", want.busy, got.busy);
            failures++;
          end
          if (got.accepted != want.accepted) begin
            $error("accepted: expected %0d, actual %0d", want.accepted, got.accepted);
            failures++;
          end
          if (m_axis_tdata[7:3] != 5'd0) begin
            $error("pad: expected 0, actual %0h", m_axis_tdata[7:3]);
            failures++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        advance_transmitter(amcstx_pkg::cmd_e'(s_axis_tuser), s_axis_tdata, nxt);
        pending_line_states.push_back(nxt);
      end
    end
  end

  // receiver: long hold-off on request, random stall bursts otherwise
  always begin
    @(negedge clk_i);
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic offer_item(input amcstx_pkg::cmd_e cmd, input logic [7:0] arg);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= arg;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic run_ticks(input int n);
    repeat (n) offer_item(amcstx_pkg::CMD_TICK, 8'($urandom));
  endtask

  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    while (pending_line_states.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_bit_time(input logic [15:0] value);
    quiesce();
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    tx_bit_time = value;
  endtask

  task automatic test_idle_ticks();
    run_ticks(4);
  endtask

  // default bit time reaches the start bit, then a faster rate mid-frame
  task automatic test_reset_bit_time();
    offer_item(amcstx_pkg::CMD_STOP, 8'hAA);
    run_ticks(93 * 2 + 1);
    set_bit_time(16'd1);
    run_ticks(42);
  endtask

  task automatic test_frame_types();
    offer_item(amcstx_pkg::CMD_PLAY, 8'hA5);
    offer_item(amcstx_pkg::CMD_VOLUME, 8'h12);
    run_ticks(66);
    set_bit_time(16'd0);
    offer_item(amcstx_pkg::CMD_VOLUME, 8'h3C);
    offer_item(amcstx_pkg::CMD_STOP, 8'h00);
    run_ticks(55);
  endtask

  task automatic test_bit_time_extremes();
    set_bit_time(16'hFFFF);
    offer_item(amcstx_pkg::CMD_STOP, 8'h5A);
    run_ticks(8);
    set_bit_time(16'd1);
    run_ticks(44);
  endtask

  task automatic test_backpressure();
    set_bit_time(16'd2);
    idle_on = 1'b0;
    @(posedge clk_i);
    hold_left = 80;
    @(negedge clk_i);
    offer_item(amcstx_pkg::CMD_PLAY, 8'($urandom));
    run_ticks(24);
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    logic [15:0] rates[3] = '{16'd1, 16'd0, 16'd2};
    amcstx_pkg::cmd_e cmd;
    for (int p = 0; p < 3; p++) begin
      set_bit_time(rates[p]);
      if (p == 2) idle_on = 1'b0;
      repeat (12) begin
        if (!tx_sending && $urandom_range(0, 2) != 0) begin
          cmd = amcstx_pkg::cmd_e'($urandom_range(1, 3));
        end else if (tx_sending && $urandom_range(0, 19) == 0) begin
          cmd = amcstx_pkg::cmd_e'($urandom_range(1, 3));
        end else begin
          cmd = amcstx_pkg::CMD_TICK;
        end
        offer_item(cmd, 8'($urandom));
      end
    end
  endtask

  initial begin
    tx_bit_time = amcstx_pkg::BIT_TIME_RESET;
    tx_line     = 1'b1;
    tx_sending  = 1'b0;
    tx_kind     = amcstx_pkg::CMD_TICK;
    tx_arg      = '0;
    tx_byte_pos = '0;
    tx_phase    = '0;
    tx_ticks    = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_idle_ticks();
    test_reset_bit_time();
    test_frame_types();
    test_bit_time_extremes();
    test_backpressure();
    test_random_traffic();
    quiesce();
    repeat (8) @(negedge clk_i);
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
